// ===== hw/rtl/glzw_pkg.sv =====
package glzw_pkg;

    // Sequencer states of the encoder.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HASH,
        ST_CHECK,
        ST_MISS,
        ST_CLEAR,
        ST_SWEEP,
        ST_FINISH,
        ST_LAST_PREFIX,
        ST_EOI
    } state_t;

    // Width of the emitted code field and of the code-width field.
    localparam int CODE_W  = 12;
    localparam int WIDTH_W = 4;

    // Left shift applied to the pixel in the first probe: the table depth is
    // doubled until it reaches 65536, and each doubling takes one off eight.
    function automatic int first_shift(input int depth);
        int steps;
        int span;
        steps = 0;
        span  = depth;
        while (span < 65536) begin
            span  = span * 2;
            steps = steps + 1;
        end
        return (steps > 8) ? 0 : 8 - steps;
    endfunction

endpackage

// ===== hw/rtl/glzw_table.sv =====
module glzw_table #(
    parameter int DEPTH  = 5003,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 33
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/glzw_probe.sv =====
module glzw_probe #(
    parameter int DEPTH  = 5003,
    parameter int ADDR_W = 13
) (
    input  logic              first_sel,
    input  logic [ADDR_W:0]   raw_hash,
    input  logic [ADDR_W-1:0] cur_idx,
    input  logic [ADDR_W-1:0] cur_disp,
    output logic [ADDR_W-1:0] idx_out,
    output logic [ADDR_W-1:0] disp_out
);

    localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W + 1)'(DEPTH);

    logic [ADDR_W:0] opa;
    logic [ADDR_W:0] opb;
    logic [ADDR_W:0] diff;
    logic [ADDR_W:0] wrap;
    logic [ADDR_W:0] res;

    // One compare-and-subtract serves both the first-probe reduction and the
    // backward step by the secondary displacement.
    always_comb begin
        opa  = first_sel ? raw_hash : {1'b0, cur_idx};
        opb  = first_sel ? DEPTH_X : {1'b0, cur_disp};
        diff = opa - opb;
        wrap = opa + DEPTH_X - opb;
        if (opa >= opb) begin
            res = diff;
        end else if (first_sel) begin
            res = opa;
        end else begin
            res = wrap;
        end
        idx_out  = res[ADDR_W-1:0];
        disp_out = (res == '0) ? ADDR_W'(1) : ADDR_W'(DEPTH_X - res);
    end

endmodule

// ===== hw/rtl/gif_lzw_encoder.sv =====
// GIF LZW encoder core. Pixel palette indices arrive one request at a time on
// the slave stream (s_tlast marks the final pixel of an image) and LZW codes
// leave on the master stream together with the bit width at which a packer
// must write each one; m_tlast is set on the end-of-information code that
// closes an image. Each image opens with CLEAR and ends with the final prefix
// and EOI. Strings live in an open-addressed hash dictionary held in a single
// memory of HASH_DEPTH entries with one registered read port; lookups start at
// (pixel << shift) XOR prefix and step backwards by a secondary displacement.
// The block takes one pixel at a time and is not ready while it works on it.
// A pixel that extends a known string passes through accept, hash, compare
// and finish, with a further compare for each collision probe, since every
// probe is a memory read followed by a compare. A pixel that misses adds a
// step to emit the prefix and write the new entry. The last pixel of an image
// adds steps for the final prefix and EOI. Whenever the dictionary must be
// emptied, on the first pixel of an image and when the code space is full, a
// clearing pass writes every entry once. Each emitted code waits until the
// output register is free, so back-pressure on the master side adds cycles.
module gif_lzw_encoder #(
    parameter int HASH_DEPTH    = 5003,
    parameter int MAX_CODE_BITS = 12,
    parameter int ROOT_BITS     = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_index
    input  logic        s_tlast,   // last_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] code_value, [15:12] code_width
    output logic        m_tlast    // last_code
);

    localparam int ADDR_W  = $clog2(HASH_DEPTH);
    localparam int CNT_W   = $clog2(HASH_DEPTH + 1);
    localparam int NFC_W   = MAX_CODE_BITS + 1;
    localparam int KEY_W   = ROOT_BITS + MAX_CODE_BITS;
    localparam int DATA_W  = 1 + KEY_W + MAX_CODE_BITS;
    localparam int SHIFT   = glzw_pkg::first_shift(HASH_DEPTH);
    localparam int CW      = glzw_pkg::CODE_W;
    localparam int WW      = glzw_pkg::WIDTH_W;

    localparam logic [CW-1:0]     CLEAR_CODE = CW'(1 << ROOT_BITS);
    localparam logic [CW-1:0]     EOI_CODE   = CW'((1 << ROOT_BITS) + 1);
    localparam logic [NFC_W-1:0]  FIRST_FREE = NFC_W'((1 << ROOT_BITS) + 2);
    localparam logic [NFC_W-1:0]  CODE_LIMIT = NFC_W'(1 << MAX_CODE_BITS);
    localparam logic [WW-1:0]     ROOT_WIDTH = WW'(ROOT_BITS + 1);
    localparam logic [WW-1:0]     MAX_WIDTH  = WW'(MAX_CODE_BITS);
    localparam logic [CNT_W-1:0]  PROBE_MAX  = CNT_W'(HASH_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(HASH_DEPTH - 1);

    glzw_pkg::state_t state_reg, state_next;

    logic [ROOT_BITS-1:0]     pix_reg, pix_next;
    logic                     last_reg, last_next;
    logic [MAX_CODE_BITS-1:0] prefix_reg, prefix_next;
    logic                     pvalid_reg, pvalid_next;
    logic [NFC_W-1:0]         nfc_reg, nfc_next;
    logic [WW-1:0]            width_reg, width_next;
    logic [ADDR_W-1:0]        idx_reg, idx_next;
    logic [ADDR_W-1:0]        disp_reg, disp_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [ADDR_W-1:0]        sweep_reg, sweep_next;
    logic                     mvalid_reg, mvalid_next;
    logic [CW-1:0]            mcode_reg, mcode_next;
    logic [WW-1:0]            mwidth_reg, mwidth_next;
    logic                     mlast_reg, mlast_next;

    // Memory word: valid bit, key, code.
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic [DATA_W-1:0]        rd_data;

    logic                     first_sel;
    logic [ADDR_W:0]          raw_hash;
    logic [ADDR_W-1:0]        probe_idx;
    logic [ADDR_W-1:0]        probe_disp;

    logic [KEY_W-1:0]         key;
    logic                     ent_valid;
    logic [KEY_W-1:0]         ent_key;
    logic [MAX_CODE_BITS-1:0] ent_code;
    logic                     hit;
    logic                     emit_ok;
    logic                     grow;
    logic [NFC_W-1:0]         width_lim;

    glzw_table #(
        .DEPTH  (HASH_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    glzw_probe #(
        .DEPTH  (HASH_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_probe (
        .first_sel (first_sel),
        .raw_hash  (raw_hash),
        .cur_idx   (idx_reg),
        .cur_disp  (disp_reg),
        .idx_out   (probe_idx),
        .disp_out  (probe_disp)
    );

    // The key is the pixel above the prefix; the first probe is the shifted
    // pixel XORed with the prefix, which always lies below twice the depth.
    assign key       = {pix_reg, prefix_reg};
    assign raw_hash  = (ADDR_W + 1)'(({{MAX_CODE_BITS{1'b0}}, pix_reg} << SHIFT)
                                     ^ {{ROOT_BITS{1'b0}}, prefix_reg});
    assign first_sel = (state_reg == glzw_pkg::ST_HASH);

    assign ent_valid = rd_data[DATA_W-1];
    assign ent_key   = rd_data[DATA_W-2:MAX_CODE_BITS];
    assign ent_code  = rd_data[MAX_CODE_BITS-1:0];
    assign hit       = ent_valid && (ent_key == key);

    // The output register may be loaded when empty or when its code leaves.
    assign emit_ok   = !mvalid_reg || m_tready;

    // Width grows after a non-CLEAR code once the next code no longer fits.
    assign width_lim = (NFC_W'(1) << width_reg) - NFC_W'(1);
    assign grow      = (width_reg < MAX_WIDTH) && (nfc_reg > width_lim);

    assign s_tready  = (state_reg == glzw_pkg::ST_IDLE);
    assign m_tvalid  = mvalid_reg;
    assign m_tdata   = {mwidth_reg, mcode_reg};
    assign m_tlast   = mlast_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            glzw_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = pvalid_reg ? glzw_pkg::ST_HASH : glzw_pkg::ST_CLEAR;
                end
            end
            glzw_pkg::ST_HASH: begin
                state_next = glzw_pkg::ST_CHECK;
            end
            glzw_pkg::ST_CHECK: begin
                if (hit) begin
                    state_next = glzw_pkg::ST_FINISH;
                end else if (!ent_valid || cnt_reg == PROBE_MAX) begin
                    state_next = glzw_pkg::ST_MISS;
                end
            end
            glzw_pkg::ST_MISS: begin
                if (emit_ok) begin
                    state_next = (nfc_reg < CODE_LIMIT) ? glzw_pkg::ST_FINISH
                                                        : glzw_pkg::ST_CLEAR;
                end
            end
            glzw_pkg::ST_CLEAR: begin
                if (emit_ok) begin
                    state_next = glzw_pkg::ST_SWEEP;
                end
            end
            glzw_pkg::ST_SWEEP: begin
                if (sweep_reg == LAST_ADDR) begin
                    state_next = glzw_pkg::ST_FINISH;
                end
            end
            glzw_pkg::ST_FINISH: begin
                state_next = last_reg ? glzw_pkg::ST_LAST_PREFIX : glzw_pkg::ST_IDLE;
            end
            glzw_pkg::ST_LAST_PREFIX: begin
                if (emit_ok) begin
                    state_next = glzw_pkg::ST_EOI;
                end
            end
            glzw_pkg::ST_EOI: begin
                if (emit_ok) begin
                    state_next = glzw_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = glzw_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, memory port and output register.
    always_comb begin
        pix_next    = pix_reg;
        last_next   = last_reg;
        prefix_next = prefix_reg;
        pvalid_next = pvalid_reg;
        nfc_next    = nfc_reg;
        width_next  = width_reg;
        idx_next    = idx_reg;
        disp_next   = disp_reg;
        cnt_next    = cnt_reg;
        sweep_next  = sweep_reg;
        mvalid_next = mvalid_reg && !m_tready;
        mcode_next  = mcode_reg;
        mwidth_next = mwidth_reg;
        mlast_next  = mlast_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = {1'b1, key, nfc_reg[MAX_CODE_BITS-1:0]};
        rd_en       = 1'b0;
        rd_addr     = probe_idx;

        case (state_reg)
            glzw_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    pix_next  = s_tdata[ROOT_BITS-1:0];
                    last_next = s_tlast;
                end
            end
            glzw_pkg::ST_HASH: begin
                rd_en     = 1'b1;
                idx_next  = probe_idx;
                disp_next = probe_disp;
                cnt_next  = '0;
            end
            glzw_pkg::ST_CHECK: begin
                if (hit) begin
                    prefix_next = ent_code;
                end else if (ent_valid && cnt_reg != PROBE_MAX) begin
                    rd_en    = 1'b1;
                    idx_next = probe_idx;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            glzw_pkg::ST_MISS: begin
                if (emit_ok) begin
                    mvalid_next = 1'b1;
                    mcode_next  = CW'(prefix_reg);
                    mwidth_next = width_reg;
                    mlast_next  = 1'b0;
                    if (grow) begin
                        width_next = width_reg + WW'(1);
                    end
                    if (nfc_reg < CODE_LIMIT) begin
                        wr_en       = 1'b1;
                        nfc_next    = nfc_reg + NFC_W'(1);
                        prefix_next = MAX_CODE_BITS'(pix_reg);
                    end
                end
            end
            glzw_pkg::ST_CLEAR: begin
                if (emit_ok) begin
                    mvalid_next = 1'b1;
                    mcode_next  = CLEAR_CODE;
                    mwidth_next = width_reg;
                    mlast_next  = 1'b0;
                    width_next  = ROOT_WIDTH;
                    sweep_next  = '0;
                end
            end
            glzw_pkg::ST_SWEEP: begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = '0;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_reg == LAST_ADDR) begin
                    prefix_next = MAX_CODE_BITS'(pix_reg);
                    pvalid_next = 1'b1;
                    nfc_next    = FIRST_FREE;
                end
            end
            glzw_pkg::ST_LAST_PREFIX: begin
                if (emit_ok) begin
                    mvalid_next = 1'b1;
                    mcode_next  = CW'(prefix_reg);
                    mwidth_next = width_reg;
                    mlast_next  = 1'b0;
                    if (grow) begin
                        width_next = width_reg + WW'(1);
                    end
                end
            end
            glzw_pkg::ST_EOI: begin
                if (emit_ok) begin
                    mvalid_next = 1'b1;
                    mcode_next  = EOI_CODE;
                    mwidth_next = width_reg;
                    mlast_next  = 1'b1;
                    pvalid_next = 1'b0;
                    prefix_next = '0;
                    nfc_next    = FIRST_FREE;
                    width_next  = ROOT_WIDTH;
                end
            end
            default: begin
                mvalid_next = mvalid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= glzw_pkg::ST_IDLE;
            prefix_reg <= '0;
            pvalid_reg <= 1'b0;
            nfc_reg    <= FIRST_FREE;
            width_reg  <= ROOT_WIDTH;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            prefix_reg <= prefix_next;
            pvalid_reg <= pvalid_next;
            nfc_reg    <= nfc_next;
            width_reg  <= width_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg    <= pix_next;
        last_reg   <= last_next;
        idx_reg    <= idx_next;
        disp_reg   <= disp_next;
        cnt_reg    <= cnt_next;
        sweep_reg  <= sweep_next;
        mcode_reg  <= mcode_next;
        mwidth_reg <= mwidth_next;
        mlast_reg  <= mlast_next;
    end

endmodule
